// ----- rtl/core/ogm_pkg.sv -----
`default_nettype none

package ogm_pkg;

    // grid size
    localparam int GRID_CELLS_DEF = 65536;

    // field widths
    localparam int IDX_W      = 16;
    localparam int VAL_W      = 8;
    localparam int OWN_W      = 3;
    localparam int CNT_W      = 4;
    localparam int THR_W      = 7;
    localparam int TDATA_W    = IDX_W + VAL_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWNER_TAG     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OCC_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE     = 2'd2;

    // register reset values
    localparam logic [OWN_W-1:0] OWNER_TAG_RST     = 3'd1;
    localparam logic [THR_W-1:0] OCC_THRESHOLD_RST = 7'd90;
    localparam logic [CNT_W-1:0] TOLERANCE_RST     = 4'd10;

    // cell values and counter limit
    localparam logic signed [VAL_W-1:0] FREE_VAL    = 8'sd0;
    localparam logic signed [VAL_W-1:0] OCC_VAL     = 8'sd100;
    localparam logic signed [VAL_W-1:0] UNKNOWN_VAL = -8'sd1;
    localparam logic [CNT_W-1:0]        CNT_MAX     = 4'd15;

    // per-cell ownership and disagreement counters
    typedef struct packed {
        logic [OWN_W-1:0] owner;
        logic [CNT_W-1:0] free_cnt;
        logic [CNT_W-1:0] occ_cnt;
    } ogm_meta_t;

    // kind of update an item asks for
    typedef struct packed {
        logic copy;
        logic obs_free;
        logic obs_occ;
    } ogm_obs_t;

endpackage

`default_nettype wire

// ----- rtl/core/ogm_store.sv -----
`default_nettype none

module ogm_store #(
    parameter int GRID_CELLS = ogm_pkg::GRID_CELLS_DEF,
    localparam int AW = $clog2(GRID_CELLS)
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             rd_en,
    input  wire logic [AW-1:0]                    rd_addr,
    input  wire logic                             wr_en,
    input  wire logic [AW-1:0]                    wr_addr,
    input  wire logic signed [ogm_pkg::VAL_W-1:0] wr_cell,
    input  wire ogm_pkg::ogm_meta_t               wr_meta,
    output logic signed [ogm_pkg::VAL_W-1:0]      rd_cell,
    output ogm_pkg::ogm_meta_t                    rd_meta,
    output logic                                  busy
);
    import ogm_pkg::*;

    localparam logic [AW-1:0] LAST_ADDR = AW'(GRID_CELLS - 1);

    logic signed [VAL_W-1:0] cell_mem [GRID_CELLS];
    ogm_meta_t               meta_mem [GRID_CELLS];

    logic                    clearing_reg, clearing_next;
    logic [AW-1:0]           clr_addr_reg, clr_addr_next;
    logic signed [VAL_W-1:0] rd_cell_reg;
    ogm_meta_t               rd_meta_reg;

    logic                    meta_we;
    logic [AW-1:0]           meta_addr;
    ogm_meta_t               meta_data;

    // clearing sweep over the owner and counter store after reset
    always_comb begin
        clearing_next = clearing_reg && (clr_addr_reg != LAST_ADDR);
        clr_addr_next = clearing_reg ? clr_addr_reg + AW'(1) : clr_addr_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // write port shared between sweep and pipeline
    always_comb begin
        meta_we   = clearing_reg || wr_en;
        meta_addr = clearing_reg ? clr_addr_reg : wr_addr;
        meta_data = clearing_reg ? '0 : wr_meta;
    end

    // cell value store, write-first on a same-beat address match
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            cell_mem[wr_addr] <= wr_cell;
        end
        if (rd_en) begin
            rd_cell_reg <= (wr_en && (wr_addr == rd_addr)) ? wr_cell : cell_mem[rd_addr];
        end
    end

    // owner and counter store
    always_ff @(posedge aclk) begin
        if (meta_we) begin
            meta_mem[meta_addr] <= meta_data;
        end
        if (rd_en) begin
            rd_meta_reg <= (meta_we && (meta_addr == rd_addr)) ? meta_data
                                                                : meta_mem[rd_addr];
        end
    end

    assign rd_cell = rd_cell_reg;
    assign rd_meta = rd_meta_reg;
    assign busy    = clearing_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ogm_merge.sv -----
`default_nettype none

module ogm_merge (
    input  wire ogm_pkg::ogm_obs_t                obs,
    input  wire logic signed [ogm_pkg::VAL_W-1:0] obs_value,
    input  wire logic signed [ogm_pkg::VAL_W-1:0] cur_cell,
    input  wire ogm_pkg::ogm_meta_t               cur_meta,
    input  wire logic [ogm_pkg::OWN_W-1:0]        owner_tag,
    input  wire logic [ogm_pkg::CNT_W-1:0]        tolerance,
    output logic signed [ogm_pkg::VAL_W-1:0]      new_cell,
    output ogm_pkg::ogm_meta_t                    new_meta
);
    import ogm_pkg::*;

    logic signed [VAL_W-1:0] target;
    logic signed [VAL_W-1:0] opposite;
    logic [CNT_W-1:0]        cnt;
    logic [CNT_W-1:0]        cnt_inc;
    logic                    owned;

    // pick target, contradicted value and counter for this observation
    always_comb begin
        target   = obs.obs_free ? FREE_VAL : OCC_VAL;
        opposite = obs.obs_free ? OCC_VAL : FREE_VAL;
        cnt      = obs.obs_free ? cur_meta.free_cnt : cur_meta.occ_cnt;
        cnt_inc  = (cnt < CNT_MAX) ? cnt + 4'd1 : cnt;
        owned    = (cur_meta.owner != '0) && (cur_meta.owner == owner_tag);
    end

    // merge rules: copy, fill unknown, owner overwrite, counted flip
    always_comb begin
        new_cell = cur_cell;
        new_meta = cur_meta;
        if (obs.copy) begin
            new_cell = obs_value;
        end else if (obs.obs_free || obs.obs_occ) begin
            if (cur_cell == UNKNOWN_VAL) begin
                new_cell       = target;
                new_meta.owner = owner_tag;
            end else if (cur_cell == opposite) begin
                if (owned) begin
                    new_cell = target;
                end else if (cnt_inc > tolerance) begin
                    new_cell          = target;
                    new_meta.free_cnt = '0;
                    new_meta.occ_cnt  = '0;
                end else if (obs.obs_free) begin
                    new_meta.free_cnt = cnt_inc;
                end else begin
                    new_meta.occ_cnt = cnt_inc;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/occupancy_grid_merge.sv -----
`default_nettype none
// pipeline: a taken input beat passes through stages a, b and c before its result shows
// throughput: one cell per cycle; all three stages, the last being the output
//   register, freeze together while a result waits on m_tready
// reset: sync active low; afterwards the owner/counter store is swept to zero,
//   one entry per cycle, so s_tready stays low until the sweep is done

module occupancy_grid_merge #(
    parameter int GRID_CELLS = ogm_pkg::GRID_CELLS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [ogm_pkg::TDATA_W-1:0]       s_tdata,  // cell_index, cell_value
    input  wire logic                              s_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [ogm_pkg::TDATA_W-1:0]            m_tdata,  // out_index, merged_value
    output logic                                   m_tlast,
    input  wire logic                              cfg_we,
    input  wire logic [ogm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ogm_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import ogm_pkg::*;

    localparam int AW = $clog2(GRID_CELLS);

    // configuration
    logic [OWN_W-1:0] owner_tag_reg, owner_tag_next;
    logic [THR_W-1:0] occ_thr_reg, occ_thr_next;
    logic [CNT_W-1:0] tolerance_reg, tolerance_next;
    logic             ffd_reg, ffd_next;

    // handshake
    logic adv;
    logic s_acc;
    logic store_busy;

    // input split
    logic [IDX_W-1:0]        s_idx;
    logic signed [VAL_W-1:0] s_val;
    logic [31:0]             s_idx_ext;
    ogm_obs_t                s_obs;

    // stage a
    logic                    a_valid_reg, a_valid_next;
    logic [IDX_W-1:0]        a_idx_reg;
    logic [AW-1:0]           a_addr_reg;
    logic signed [VAL_W-1:0] a_val_reg;
    logic                    a_last_reg;
    logic                    a_in_range_reg;
    ogm_obs_t                a_obs_reg;

    // stage b
    logic                    b_valid_reg, b_valid_next;
    logic [IDX_W-1:0]        b_idx_reg;
    logic [AW-1:0]           b_addr_reg;
    logic signed [VAL_W-1:0] b_val_reg;
    logic                    b_last_reg;
    logic                    b_in_range_reg;
    ogm_obs_t                b_obs_reg;

    // stage c / output
    logic                    c_valid_reg, c_valid_next;
    logic                    c_we_reg, c_we_next;
    logic [AW-1:0]           c_addr_reg;
    logic signed [VAL_W-1:0] c_cell_reg;
    ogm_meta_t               c_meta_reg;
    logic [IDX_W-1:0]        c_idx_reg;
    logic signed [VAL_W-1:0] c_merged_reg;
    logic                    c_last_reg;

    // store and merge signals
    logic signed [VAL_W-1:0] rd_cell;
    ogm_meta_t               rd_meta;
    logic                    fwd;
    logic signed [VAL_W-1:0] cur_cell;
    ogm_meta_t               cur_meta;
    logic signed [VAL_W-1:0] new_cell;
    ogm_meta_t               new_meta;

    // configuration writes
    always_comb begin
        owner_tag_next = owner_tag_reg;
        occ_thr_next   = occ_thr_reg;
        tolerance_next = tolerance_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_OWNER_TAG:     owner_tag_next = cfg_data[OWN_W-1:0];
                CFG_OCC_THRESHOLD: occ_thr_next   = cfg_data[THR_W-1:0];
                CFG_TOLERANCE:     tolerance_next = cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // global advance: whole pipeline moves when the output slot frees
    assign adv      = !c_valid_reg || m_tready;
    assign s_tready = adv && !store_busy;
    assign s_acc    = s_tvalid && s_tready;

    // classify the incoming beat
    always_comb begin
        s_idx          = s_tdata[IDX_W-1:0];
        s_val          = s_tdata[TDATA_W-1:IDX_W];
        s_idx_ext      = 32'(s_idx);
        s_obs.copy     = !ffd_reg;
        s_obs.obs_free = ffd_reg && (s_val == FREE_VAL);
        s_obs.obs_occ  = ffd_reg && ($signed(s_val) > $signed({1'b0, occ_thr_reg}));
    end

    // first frame ends on its last beat
    assign ffd_next = ffd_reg || (s_acc && s_tlast);

    // forward from the write still waiting in stage c
    always_comb begin
        fwd      = c_we_reg && (c_addr_reg == b_addr_reg);
        cur_cell = fwd ? c_cell_reg : rd_cell;
        cur_meta = fwd ? c_meta_reg : rd_meta;
    end

    // valid bits
    always_comb begin
        a_valid_next = a_valid_reg;
        b_valid_next = b_valid_reg;
        c_valid_next = c_valid_reg;
        c_we_next    = c_we_reg;
        if (adv) begin
            a_valid_next = s_acc;
            b_valid_next = a_valid_reg;
            c_valid_next = b_valid_reg;
            c_we_next    = b_valid_reg && b_in_range_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            owner_tag_reg <= OWNER_TAG_RST;
            occ_thr_reg   <= OCC_THRESHOLD_RST;
            tolerance_reg <= TOLERANCE_RST;
            ffd_reg       <= 1'b0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            c_we_reg      <= 1'b0;
        end else begin
            owner_tag_reg <= owner_tag_next;
            occ_thr_reg   <= occ_thr_next;
            tolerance_reg <= tolerance_next;
            ffd_reg       <= ffd_next;
            a_valid_reg   <= a_valid_next;
            b_valid_reg   <= b_valid_next;
            c_valid_reg   <= c_valid_next;
            c_we_reg      <= c_we_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            a_idx_reg      <= s_idx;
            a_addr_reg     <= s_idx_ext[AW-1:0];
            a_val_reg      <= s_val;
            a_last_reg     <= s_tlast;
            a_in_range_reg <= s_idx_ext < 32'(GRID_CELLS);
            a_obs_reg      <= s_obs;
        end
        if (adv) begin
            b_idx_reg      <= a_idx_reg;
            b_addr_reg     <= a_addr_reg;
            b_val_reg      <= a_val_reg;
            b_last_reg     <= a_last_reg;
            b_in_range_reg <= a_in_range_reg;
            b_obs_reg      <= a_obs_reg;
            c_addr_reg     <= b_addr_reg;
            c_cell_reg     <= new_cell;
            c_meta_reg     <= new_meta;
            c_idx_reg      <= b_idx_reg;
            c_merged_reg   <= b_in_range_reg ? new_cell : FREE_VAL;
            c_last_reg     <= b_last_reg;
        end
    end

    ogm_store #(
        .GRID_CELLS (GRID_CELLS)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (adv),
        .rd_addr (a_addr_reg),
        .wr_en   (adv && c_we_reg),
        .wr_addr (c_addr_reg),
        .wr_cell (c_cell_reg),
        .wr_meta (c_meta_reg),
        .rd_cell (rd_cell),
        .rd_meta (rd_meta),
        .busy    (store_busy)
    );

    ogm_merge u_merge (
        .obs       (b_obs_reg),
        .obs_value (b_val_reg),
        .cur_cell  (cur_cell),
        .cur_meta  (cur_meta),
        .owner_tag (owner_tag_reg),
        .tolerance (tolerance_reg),
        .new_cell  (new_cell),
        .new_meta  (new_meta)
    );

    // result channel
    assign m_tvalid = c_valid_reg;
    assign m_tdata  = {c_merged_reg, c_idx_reg};
    assign m_tlast  = c_last_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ogm_checker.sv -----
`default_nettype none

module ogm_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_tvalid,
    input wire logic                        s_tready,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [ogm_pkg::TDATA_W-1:0] m_tdata,
    input wire logic                        m_tlast
);
    logic       s_beat;
    logic       m_beat;
    logic [2:0] inflight_reg, inflight_next;

    assign s_beat = s_tvalid && s_tready;
    assign m_beat = m_tvalid && m_tready;

    // beats taken but not yet delivered
    always_comb begin
        inflight_next = inflight_reg;
        if (s_beat && !m_beat) begin
            inflight_next = inflight_reg + 3'd1;
        end else if (!s_beat && m_beat) begin
            inflight_next = inflight_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    // reset empties the output and holds off input during the sweep
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("beat activity right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // a stalled output freezes the pipeline, so no input beat is taken
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    // no more than three cells in the pipeline
    a_inflight_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= 3'd3)
        else $error("too many cells in flight");

    // no result without a cell behind it
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> inflight_reg != 3'd0)
        else $error("result without an accepted cell");

endmodule

bind occupancy_grid_merge ogm_checker u_ogm_checker (.*);

`default_nettype wire
